// ===== sv/ppa_pkg.sv =====
// ----------------------------------------------------------------------------
// ppa_pkg
// Shared types and constants of the projection profile accumulator:
// field widths, configuration register indexes and size limits.
// ----------------------------------------------------------------------------
package ppa_pkg;

    // default largest image side, also the profile store depth
    localparam int MAX_DIM_DEFAULT = 1024;

    // field widths
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int PIX_W      = 8;
    localparam int INDEX_W    = 10;
    localparam int BAR_W      = 10;
    localparam int STORE_W    = 18;

    // saturation limits
    localparam logic [STORE_W-1:0] STORE_MAX = {STORE_W{1'b1}};
    localparam logic [BAR_W-1:0]   BAR_MAX   = {BAR_W{1'b1}};

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1,
        REG_DIRECTION    = 2'd2,
        REG_PIXEL_FORMAT = 2'd3
    } cfg_reg_t;

    // request kinds
    typedef enum logic {
        KIND_PIXEL = 1'b0,
        KIND_READ  = 1'b1
    } req_kind_t;

    // profile direction
    typedef enum logic {
        DIR_VERTICAL   = 1'b0,
        DIR_HORIZONTAL = 1'b1
    } direction_t;

    // pixel format
    typedef enum logic {
        FMT_BILEVEL   = 1'b0,
        FMT_GREYSCALE = 1'b1
    } pixel_format_t;

    // reset values of the size registers
    localparam logic [CFG_DATA_W-1:0] SIZE_RESET = 11'd1024;

endpackage

// ===== sv/ppa_req_if.sv =====
// ----------------------------------------------------------------------------
// ppa_req_if
// Request channel: a pixel in raster order or a read of one profile entry.
// ----------------------------------------------------------------------------
interface ppa_req_if;
    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic [ppa_pkg::PIX_W-1:0]     pixel_value;
    logic [ppa_pkg::INDEX_W-1:0]   read_index;

    modport source (output valid, output kind, output pixel_value, output read_index,
                    input ready);
    modport sink   (input valid, input kind, input pixel_value, input read_index,
                    output ready);
endinterface

// ===== sv/ppa_rsp_if.sv =====
// ----------------------------------------------------------------------------
// ppa_rsp_if
// Result channel: bar length of one profile entry or a frame end marker.
// ----------------------------------------------------------------------------
interface ppa_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [ppa_pkg::INDEX_W-1:0]   profile_index;
    logic [ppa_pkg::BAR_W-1:0]     bar_length;
    logic                          frame_complete;

    modport source (output valid, output profile_index, output bar_length,
                    output frame_complete, input ready);
    modport sink   (input valid, input profile_index, input bar_length,
                    input frame_complete, output ready);
endinterface

// ===== sv/ppa_cfg_if.sv =====
// ----------------------------------------------------------------------------
// ppa_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface ppa_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [ppa_pkg::CFG_IDX_W-1:0]    index;
    logic [ppa_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/projection_profile_accumulator.sv =====
// ----------------------------------------------------------------------------
// projection_profile_accumulator
// Sums pixels per column (vertical) or per row (horizontal) into a profile
// store and returns clamped bar lengths on read requests.
//
//   channel  modport  moves
//   -------  -------  ----------------------------------------------------
//   req      sink     pixel (kind 0) or profile entry read (kind 1)
//   rsp      source   profile_index, bar_length, frame_complete
//   cfg      sink     register index and data, always ready
//
// One request per cycle while not stalled. A result passes the profile store
// read register and the read-modify-write stage 1 behind it before it
// reaches the output register.
// A write back that overlaps the next read of the same entry is forwarded.
// Requests stall only while a result waits in a full output register.
// Reset clears positions, the frame flag and valid bits, loads config defaults;
// the store is written by the first row (vertical) or first column (horizontal).
// ----------------------------------------------------------------------------
module projection_profile_accumulator #(
    parameter int MAX_DIM = ppa_pkg::MAX_DIM_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    ppa_req_if.sink      req,
    ppa_rsp_if.source    rsp,
    ppa_cfg_if.sink      cfg
);

    localparam int AW   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DW   = $clog2(MAX_DIM + 1);
    localparam int CW   = (DW > ppa_pkg::CFG_DATA_W) ? DW : ppa_pkg::CFG_DATA_W;
    localparam int BW   = (CW > ppa_pkg::STORE_W) ? CW : ppa_pkg::STORE_W;
    localparam int SW   = ppa_pkg::STORE_W;

    // configuration registers
    logic [ppa_pkg::CFG_DATA_W-1:0] width_reg;
    logic [ppa_pkg::CFG_DATA_W-1:0] height_reg;
    logic                           direction_reg;
    logic                           format_reg;

    // position and frame state
    logic [AW-1:0] col_reg, col_next;
    logic [AW-1:0] row_reg, row_next;
    logic          frame_done_reg;

    // stage 1 (store data valid)
    logic          s1_valid_reg;
    logic          s1_kind_reg;
    logic [AW-1:0] s1_addr_reg;
    logic          s1_first_reg;
    logic [ppa_pkg::PIX_W-1:0]   s1_add_reg;
    logic          s1_last_reg;
    logic [ppa_pkg::INDEX_W-1:0] s1_index_reg;
    logic          s1_oor_reg;
    logic          s1_flag_reg;
    logic [CW-1:0] s1_limit_reg;
    logic          s1_grey_reg;

    // write back bypass
    logic          wb_valid_reg;
    logic [AW-1:0] wb_addr_reg;
    logic [SW-1:0] wb_data_reg;

    // output register
    logic                        out_valid_reg;
    logic [ppa_pkg::INDEX_W-1:0] out_index_reg;
    logic [ppa_pkg::BAR_W-1:0]   out_bar_reg;
    logic                        out_fc_reg;

    // profile store
    logic [SW-1:0] store_mem [MAX_DIM];
    logic [SW-1:0] rd_data_reg;

    logic          req_fire;
    logic          is_pixel;
    logic [CW-1:0] w_eff;
    logic [CW-1:0] h_eff;
    logic [CW-1:0] len;
    logic [CW-1:0] limit;
    logic [CW-1:0] ridx_ext;
    logic          first;
    logic          col_wrap;
    logic          row_wrap;
    logic          last;
    logic [AW-1:0] px_addr;
    logic [AW-1:0] rd_addr;
    logic [ppa_pkg::PIX_W-1:0] add;
    logic          s1_has_result;
    logic          out_free;
    logic          s1_fire;
    logic          wr_en;
    logic [SW-1:0] operand;
    logic [SW-1:0] base;
    logic [SW:0]   sum;
    logic [SW-1:0] sum_sat;
    logic [SW-1:0] scaled;
    logic [BW-1:0] v_ext;
    logic [BW-1:0] lim_ext;
    logic [BW-1:0] clipped;
    logic [ppa_pkg::BAR_W-1:0] bar;

    // configuration writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= ppa_pkg::SIZE_RESET;
            height_reg    <= ppa_pkg::SIZE_RESET;
            direction_reg <= ppa_pkg::DIR_VERTICAL;
            format_reg    <= ppa_pkg::FMT_BILEVEL;
        end
        else if (cfg.valid)
        begin
            unique case (ppa_pkg::cfg_reg_t'(cfg.index))
                ppa_pkg::REG_IMAGE_WIDTH:  width_reg     <= cfg.data;
                ppa_pkg::REG_IMAGE_HEIGHT: height_reg    <= cfg.data;
                ppa_pkg::REG_DIRECTION:    direction_reg <= cfg.data[0];
                ppa_pkg::REG_PIXEL_FORMAT: format_reg    <= cfg.data[0];
                default: ;
            endcase
        end
    end

    // effective image sizes, zero acts as one, clamp at store depth
    always_comb
    begin
        if (width_reg == '0)
            w_eff = CW'(1);
        else if (CW'(width_reg) > CW'(MAX_DIM))
            w_eff = CW'(MAX_DIM);
        else
            w_eff = CW'(width_reg);

        if (height_reg == '0)
            h_eff = CW'(1);
        else if (CW'(height_reg) > CW'(MAX_DIM))
            h_eff = CW'(MAX_DIM);
        else
            h_eff = CW'(height_reg);
    end

    // output and stage 1 handshake
    assign s1_has_result = (s1_kind_reg == ppa_pkg::KIND_READ) || s1_last_reg;
    assign out_free      = !out_valid_reg || rsp.ready;
    assign s1_fire       = s1_valid_reg && (!s1_has_result || out_free);
    assign req.ready     = !s1_valid_reg || s1_fire;
    assign req_fire      = req.valid && req.ready;
    assign is_pixel      = (req.kind == ppa_pkg::KIND_PIXEL);

    // stage 0: address, position step and read side limits
    always_comb
    begin
        add      = (format_reg == ppa_pkg::FMT_GREYSCALE) ? req.pixel_value
                 : ppa_pkg::PIX_W'(req.pixel_value != '0);
        px_addr  = (direction_reg == ppa_pkg::DIR_HORIZONTAL) ? row_reg : col_reg;
        first    = (direction_reg == ppa_pkg::DIR_HORIZONTAL) ? (col_reg == '0)
                 : (row_reg == '0);
        col_wrap = (CW'(col_reg) + CW'(1)) >= w_eff;
        row_wrap = (CW'(row_reg) + CW'(1)) >= h_eff;
        last     = col_wrap && row_wrap;
        col_next = col_wrap ? '0 : col_reg + AW'(1);
        row_next = row_reg;
        if (col_wrap)
            row_next = row_wrap ? '0 : row_reg + AW'(1);

        ridx_ext = CW'(req.read_index);
        len      = (direction_reg == ppa_pkg::DIR_HORIZONTAL) ? h_eff : w_eff;
        limit    = ((direction_reg == ppa_pkg::DIR_HORIZONTAL) ? w_eff : h_eff) - CW'(1);
        rd_addr  = is_pixel ? px_addr : ridx_ext[AW-1:0];
    end

    // positions and frame flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg        <= '0;
            row_reg        <= '0;
            frame_done_reg <= 1'b0;
        end
        else if (req_fire && is_pixel)
        begin
            col_reg        <= col_next;
            row_reg        <= row_next;
            frame_done_reg <= last;
        end
    end

    // stage 1 control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (req.ready)
            s1_valid_reg <= req.valid;
    end

    // stage 1 payload
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            s1_kind_reg  <= req.kind;
            s1_addr_reg  <= rd_addr;
            s1_first_reg <= first;
            s1_add_reg   <= add;
            s1_last_reg  <= is_pixel && last;
            s1_index_reg <= req.read_index;
            s1_oor_reg   <= ridx_ext >= len;
            s1_flag_reg  <= frame_done_reg;
            s1_limit_reg <= limit;
            s1_grey_reg  <= format_reg;
        end
    end

    // profile store read port
    always_ff @(posedge clk)
    begin
        if (req_fire)
            rd_data_reg <= store_mem[rd_addr];
    end

    // profile store write port
    assign wr_en = s1_fire && (s1_kind_reg == ppa_pkg::KIND_PIXEL);

    always_ff @(posedge clk)
    begin
        if (wr_en)
            store_mem[s1_addr_reg] <= sum_sat;
    end

    // bypass of the latest write back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wb_valid_reg <= 1'b0;
        else if (wr_en)
            wb_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            wb_addr_reg <= s1_addr_reg;
            wb_data_reg <= sum_sat;
        end
    end

    // stage 1: accumulate with saturation, or scale and clamp the bar
    always_comb
    begin
        operand = (wb_valid_reg && (wb_addr_reg == s1_addr_reg)) ? wb_data_reg
                : rd_data_reg;
        base    = s1_first_reg ? '0 : operand;
        sum     = {1'b0, base} + (SW + 1)'(s1_add_reg);
        sum_sat = sum[SW] ? ppa_pkg::STORE_MAX : sum[SW-1:0];

        scaled  = s1_grey_reg ? (operand >> ppa_pkg::PIX_W) : operand;
        v_ext   = BW'(scaled);
        lim_ext = BW'(s1_limit_reg);
        clipped = (v_ext > lim_ext) ? lim_ext : v_ext;
        if (clipped > BW'(ppa_pkg::BAR_MAX))
            bar = ppa_pkg::BAR_MAX;
        else
            bar = clipped[ppa_pkg::BAR_W-1:0];
        if (s1_oor_reg)
            bar = '0;
    end

    // output register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= s1_valid_reg && s1_has_result;
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (out_free && s1_valid_reg && s1_has_result)
        begin
            if (s1_kind_reg == ppa_pkg::KIND_READ)
            begin
                out_index_reg <= s1_index_reg;
                out_bar_reg   <= bar;
                out_fc_reg    <= s1_flag_reg;
            end
            else
            begin
                out_index_reg <= '0;
                out_bar_reg   <= '0;
                out_fc_reg    <= 1'b1;
            end
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.profile_index  = out_index_reg;
    assign rsp.bar_length     = out_bar_reg;
    assign rsp.frame_complete = out_fc_reg;

endmodule

// ===== sv/ppa_checker.sv =====
// ----------------------------------------------------------------------------
// ppa_checker
// Port level checks of the projection profile accumulator, bound to the
// top level.
// ----------------------------------------------------------------------------
module ppa_checker (
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic rsp_valid,
    input logic rsp_ready
);

    // a pending result stays offered until taken
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result dropped before it was taken");

    // a new result follows an accepted request through stage 1
    a_rsp_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
        else $error("result without a request two cycles earlier");

    // requests stall only behind a blocked result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !req_ready |-> rsp_valid && !rsp_ready)
        else $error("request stalled while the result side is free");

endmodule

bind projection_profile_accumulator ppa_checker u_ppa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready)
);

// ===== tb/projection_profile_accumulator_tb.sv =====
// ----------------------------------------------------------------------------
// projection_profile_accumulator_tb
// Self-checking bench for the projection profile accumulator. Pixel frames
// and profile reads go in under many image sizes, directions and formats.
// Every result is compared with a local prediction of the column and row
// sums, with random gaps on the request side and stalls on the result side.
// ----------------------------------------------------------------------------
module projection_profile_accumulator_tb;

    localparam int PROFILE_DEPTH = ppa_pkg::MAX_DIM_DEFAULT;
    localparam int SETTLE_CYCLES = 8;
    localparam int IDLE_LIMIT    = 1000;
    localparam int RANDOM_ITEMS  = 560;
    localparam int REPORT_LIMIT  = 10;

    // one returned bar or frame end marker
    typedef struct packed {
        logic [ppa_pkg::INDEX_W-1:0] profile_index;
        logic [ppa_pkg::BAR_W-1:0]   bar_length;
        logic                        frame_complete;
    } bar_result_t;

    logic clk;
    logic rst_n;

    ppa_req_if req_ch ();
    ppa_rsp_if rsp_ch ();
    ppa_cfg_if cfg_ch ();

    projection_profile_accumulator dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // predicted state of the block
    logic [ppa_pkg::STORE_W-1:0]    profile_sums [PROFILE_DEPTH];
    bit                             entry_written [PROFILE_DEPTH];
    int unsigned                    col_pos;
    int unsigned                    row_pos;
    bit                             frame_flag;
    logic [ppa_pkg::CFG_DATA_W-1:0] width_reg;
    logic [ppa_pkg::CFG_DATA_W-1:0] height_reg;
    ppa_pkg::direction_t            dir_reg;
    ppa_pkg::pixel_format_t         fmt_reg;

    bar_result_t pending_bars[$];

    // bookkeeping
    int unsigned error_count;
    int unsigned items_sent;
    int unsigned pixels_sent;
    int unsigned reads_sent;
    int unsigned frames_seen;
    int unsigned results_checked;
    int unsigned burst_left;
    int unsigned idle_cycles;
    logic [31:0] rx_cycle;

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // size register as the block uses it
    function automatic int unsigned active_dim(input logic [ppa_pkg::CFG_DATA_W-1:0] r);
        if (r == 0)
            return 1;
        if (r > PROFILE_DEPTH)
            return PROFILE_DEPTH;
        return r;
    endfunction

    // accumulate one pixel and step the raster position
    function automatic void predict_pixel(input logic [ppa_pkg::PIX_W-1:0] pv);
        int unsigned w;
        int unsigned h;
        int unsigned add;
        int unsigned idx;
        int unsigned sum;
        bit          opens_entry;
        bit          frame_end;
        w = active_dim(width_reg);
        h = active_dim(height_reg);
        add = (fmt_reg == ppa_pkg::FMT_GREYSCALE) ? pv : ((pv != 0) ? 1 : 0);
        idx = ((dir_reg == ppa_pkg::DIR_HORIZONTAL) ? row_pos : col_pos) % PROFILE_DEPTH;
        opens_entry = (dir_reg == ppa_pkg::DIR_HORIZONTAL) ? (col_pos == 0)
                                                           : (row_pos == 0);
        frame_end = 1'b0;
        if (opens_entry)
            profile_sums[idx] = ppa_pkg::STORE_W'(add);
        else
        begin
            sum = profile_sums[idx] + add;
            profile_sums[idx] = (sum > ppa_pkg::STORE_MAX) ? ppa_pkg::STORE_MAX
                                                           : ppa_pkg::STORE_W'(sum);
        end
        entry_written[idx] = 1'b1;
        frame_flag = 1'b0;
        if (col_pos + 1 >= w)
        begin
            col_pos = 0;
            if (row_pos + 1 >= h)
            begin
                row_pos = 0;
                frame_end = 1'b1;
            end
            else
                row_pos++;
        end
        else
            col_pos++;
        if (frame_end)
        begin
            frame_flag = 1'b1;
            frames_seen++;
            pending_bars.push_back('{'0, '0, 1'b1});
        end
    endfunction

    // bar length of one entry, clamped to one less than the other image side
    function automatic void predict_read(input logic [ppa_pkg::INDEX_W-1:0] ri);
        int unsigned len;
        int unsigned limit;
        int unsigned v;
        int unsigned bar;
        len = (dir_reg == ppa_pkg::DIR_HORIZONTAL) ? active_dim(height_reg)
                                                   : active_dim(width_reg);
        limit = ((dir_reg == ppa_pkg::DIR_HORIZONTAL) ? active_dim(width_reg)
                                                      : active_dim(height_reg)) - 1;
        bar = 0;
        if (ri < len)
        begin
            v = profile_sums[ri];
            if (fmt_reg == ppa_pkg::FMT_GREYSCALE)
                v = v >> 8;
            bar = (v > limit) ? limit : v;
            if (bar > ppa_pkg::BAR_MAX)
                bar = ppa_pkg::BAR_MAX;
        end
        pending_bars.push_back('{ri, bar[ppa_pkg::BAR_W-1:0], frame_flag});
    endfunction

    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= REPORT_LIMIT)
            $display("ERROR: %s", msg);
    endtask

    // one request with random bursts and gaps in front of it
    task automatic send_request(input ppa_pkg::req_kind_t k,
                                input logic [ppa_pkg::PIX_W-1:0] pv,
                                input logic [ppa_pkg::INDEX_W-1:0] ri);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        req_ch.valid       <= 1'b1;
        req_ch.kind        <= k;
        req_ch.pixel_value <= pv;
        req_ch.read_index  <= ri;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
        burst_left--;
        items_sent++;
        if (k == ppa_pkg::KIND_PIXEL)
        begin
            pixels_sent++;
            predict_pixel(pv);
        end
        else
        begin
            reads_sent++;
            predict_read(ri);
        end
    endtask

    task automatic send_pixel(input logic [ppa_pkg::PIX_W-1:0] pv);
        send_request(ppa_pkg::KIND_PIXEL, pv,
                     ppa_pkg::INDEX_W'($urandom_range(0, PROFILE_DEPTH - 1)));
    endtask

    task automatic send_read(input logic [ppa_pkg::INDEX_W-1:0] ri);
        send_request(ppa_pkg::KIND_READ, ppa_pkg::PIX_W'($urandom_range(0, 255)), ri);
    endtask

    function automatic logic [ppa_pkg::PIX_W-1:0] random_pixel();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            default: return ppa_pkg::PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [ppa_pkg::CFG_DATA_W-1:0] pick_dim();
        case ($urandom_range(0, 19))
            0: return '0;
            1: return ppa_pkg::CFG_DATA_W'(1);
            default: return ppa_pkg::CFG_DATA_W'($urandom_range(2, 12));
        endcase
    endfunction

    // read index that never touches an entry still unwritten
    function automatic bit pick_read_index(output logic [ppa_pkg::INDEX_W-1:0] ri);
        int unsigned len;
        len = (dir_reg == ppa_pkg::DIR_HORIZONTAL) ? active_dim(height_reg)
                                                   : active_dim(width_reg);
        ri = '0;
        if (len < PROFILE_DEPTH && $urandom_range(0, 3) == 0)
        begin
            ri = ppa_pkg::INDEX_W'($urandom_range(len, PROFILE_DEPTH - 1));
            return 1'b1;
        end
        for (int t = 0; t < 16; t++)
        begin
            ri = ppa_pkg::INDEX_W'($urandom_range(0, len - 1));
            if (entry_written[ri])
                return 1'b1;
        end
        if (len < PROFILE_DEPTH)
        begin
            ri = ppa_pkg::INDEX_W'($urandom_range(len, PROFILE_DEPTH - 1));
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic random_read();
        logic [ppa_pkg::INDEX_W-1:0] ri;
        if (pick_read_index(ri))
            send_read(ri);
    endtask

    // pixels with reads mixed in until the raster is back at the origin
    task automatic finish_frame(input int unsigned read_pct);
        do
        begin
            if ($urandom_range(0, 99) < read_pct)
                random_read();
            send_pixel(random_pixel());
        end
        while (col_pos != 0 || row_pos != 0);
    endtask

    // drop valid, wait for all results and for the pipeline to empty
    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_bars.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input ppa_pkg::cfg_reg_t r,
                                  input logic [ppa_pkg::CFG_DATA_W-1:0] d);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= r;
        cfg_ch.data  <= d;
        @(posedge clk);
        while (cfg_ch.ready !== 1'b1)
            @(posedge clk);
        case (r)
            ppa_pkg::REG_IMAGE_WIDTH:  width_reg  = d;
            ppa_pkg::REG_IMAGE_HEIGHT: height_reg = d;
            ppa_pkg::REG_DIRECTION:    dir_reg    = ppa_pkg::direction_t'(d[0]);
            ppa_pkg::REG_PIXEL_FORMAT: fmt_reg    = ppa_pkg::pixel_format_t'(d[0]);
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [ppa_pkg::CFG_DATA_W-1:0] w,
                                  input logic [ppa_pkg::CFG_DATA_W-1:0] h,
                                  input ppa_pkg::direction_t d,
                                  input ppa_pkg::pixel_format_t f);
        write_register(ppa_pkg::REG_IMAGE_WIDTH, w);
        write_register(ppa_pkg::REG_IMAGE_HEIGHT, h);
        write_register(ppa_pkg::REG_DIRECTION, ppa_pkg::CFG_DATA_W'(d));
        write_register(ppa_pkg::REG_PIXEL_FORMAT, ppa_pkg::CFG_DATA_W'(f));
        cfg_ch.valid <= 1'b0;
    endtask

    // column counts with clamping, partial sum and out of range reads
    task automatic test_vertical_bilevel();
        wait_idle();
        apply_settings(3, 2, ppa_pkg::DIR_VERTICAL, ppa_pkg::FMT_BILEVEL);
        send_pixel(8'd0);
        send_pixel(8'd255);
        send_pixel(8'd1);
        send_read(0);
        send_pixel(8'd7);
        send_pixel(8'd0);
        send_pixel(8'd128);
        send_read(0);
        send_read(1);
        send_read(2);
        send_read(10'd1023);
    endtask

    // row sums scaled by 1/256, frame flag cleared by the next pixel
    task automatic test_horizontal_greyscale();
        wait_idle();
        apply_settings(2, 3, ppa_pkg::DIR_HORIZONTAL, ppa_pkg::FMT_GREYSCALE);
        repeat (6) send_pixel(8'd255);
        send_read(0);
        send_read(2);
        send_read(3);
        send_pixel(8'd0);
        send_read(0);
        finish_frame(0);
    endtask

    // shrink the width while the raster sits beyond the new edge
    task automatic test_midframe_resize();
        wait_idle();
        apply_settings(6, 4, ppa_pkg::DIR_VERTICAL, ppa_pkg::FMT_BILEVEL);
        repeat (8) send_pixel(random_pixel());
        wait_idle();
        apply_settings(2, 4, ppa_pkg::DIR_VERTICAL, ppa_pkg::FMT_BILEVEL);
        finish_frame(20);
        repeat (4) random_read();
    endtask

    // out of range sizes, zero sizes acting as one, single row images
    task automatic test_size_extremes();
        wait_idle();
        apply_settings(11'd2047, 2, ppa_pkg::DIR_VERTICAL, ppa_pkg::FMT_GREYSCALE);
        repeat (48) send_pixel(random_pixel());
        send_read(0);
        send_read(10'd47);
        wait_idle();
        apply_settings(0, 6, ppa_pkg::DIR_HORIZONTAL, ppa_pkg::FMT_BILEVEL);
        finish_frame(20);
        finish_frame(20);
        repeat (8) random_read();
        wait_idle();
        apply_settings(5, 1, ppa_pkg::DIR_HORIZONTAL, ppa_pkg::FMT_GREYSCALE);
        finish_frame(10);
        repeat (4) random_read();
        wait_idle();
        apply_settings(3, 0, ppa_pkg::DIR_VERTICAL, ppa_pkg::FMT_BILEVEL);
        finish_frame(30);
        finish_frame(30);
        repeat (4) random_read();
    endtask

    // whole frames under random settings with reads interleaved
    task automatic test_random_frames();
        int unsigned start_items;
        start_items = items_sent;
        while (items_sent - start_items < RANDOM_ITEMS)
        begin
            wait_idle();
            apply_settings(pick_dim(), pick_dim(),
                           ppa_pkg::direction_t'($urandom_range(0, 1)),
                           ppa_pkg::pixel_format_t'($urandom_range(0, 1)));
            repeat ($urandom_range(1, 3)) finish_frame($urandom_range(0, 40));
            repeat ($urandom_range(0, 4)) random_read();
        end
    endtask

    // result checker and receiver stall pattern
    always @(posedge clk)
    begin : check_results
        bar_result_t got;
        bar_result_t want;
        if (!rst_n)
        begin
            rx_cycle     <= '0;
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            begin
                got = '{rsp_ch.profile_index, rsp_ch.bar_length, rsp_ch.frame_complete};
                results_checked++;
                if (pending_bars.size() == 0)
                    report_error($sformatf("unexpected result idx %0d bar %0d done %0b",
                                           got.profile_index, got.bar_length,
                                           got.frame_complete));
                else
                begin
                    want = pending_bars.pop_front();
                    if (got.profile_index !== want.profile_index
                        || got.bar_length !== want.bar_length
                        || got.frame_complete !== want.frame_complete)
                        report_error($sformatf(
                            "mismatch: expected idx %0d bar %0d done %0b, got idx %0d bar %0d done %0b",
                            want.profile_index, want.bar_length, want.frame_complete,
                            got.profile_index, got.bar_length, got.frame_complete));
                end
            end
            rx_cycle <= rx_cycle + 1;
            case (rx_cycle[9:8])
                2'd0: rsp_ch.ready <= 1'b1;
                2'd1: rsp_ch.ready <= 1'($urandom_range(0, 1));
                2'd2: rsp_ch.ready <= (rx_cycle[1:0] != 2'd0);
                default: rsp_ch.ready <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    // watchdog on cycles without any accepted request or result
    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout after %0d idle cycles", idle_cycles);
                $display("simulation failed");
                $finish;
            end
        end
    end

    // test sequence
    initial
    begin
        rst_n              <= 1'b0;
        req_ch.valid       <= 1'b0;
        req_ch.kind        <= ppa_pkg::KIND_PIXEL;
        req_ch.pixel_value <= '0;
        req_ch.read_index  <= '0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.index       <= ppa_pkg::REG_IMAGE_WIDTH;
        cfg_ch.data        <= '0;
        error_count     = 0;
        items_sent      = 0;
        pixels_sent     = 0;
        reads_sent      = 0;
        frames_seen     = 0;
        results_checked = 0;
        burst_left      = 0;
        col_pos         = 0;
        row_pos         = 0;
        frame_flag      = 1'b0;
        width_reg       = ppa_pkg::SIZE_RESET;
        height_reg      = ppa_pkg::SIZE_RESET;
        dir_reg         = ppa_pkg::DIR_VERTICAL;
        fmt_reg         = ppa_pkg::FMT_BILEVEL;
        for (int i = 0; i < PROFILE_DEPTH; i++)
        begin
            profile_sums[i]  = '0;
            entry_written[i] = 1'b0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_vertical_bilevel();
        test_horizontal_greyscale();
        test_midframe_resize();
        test_size_extremes();
        test_random_frames();
        wait_idle();

        $display("covered %0d pixels in %0d frames and %0d profile reads",
                 pixels_sent, frames_seen, reads_sent);
        $display("checked %0d results, %0d errors", results_checked, error_count);
        if (error_count == 0 && pending_bars.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
